>>> src/cets_pkg.sv
// ----------------------------------------------------------------------------
// cets_pkg: shared types and constants for the counter extend / time split unit
// Holds the field widths, the clock limits and the control word that the
// top level sends to each bit-serial divider stage.
// ----------------------------------------------------------------------------
`default_nettype none

package cets_pkg;

    // Field widths fixed by the interface
    localparam int SAMPLE_W  = 32;
    localparam int MHZ_W     = 13;
    localparam int SUB_W     = 10;
    localparam int SECONDS_W = 44;
    localparam int TOTAL_W   = 64;

    // Clock register limits and reset value
    localparam logic [MHZ_W-1:0] CLK_MHZ_RESET = 13'd80;
    localparam logic [MHZ_W-1:0] CLK_MHZ_MIN   = 13'd1;
    localparam logic [MHZ_W-1:0] CLK_MHZ_MAX   = 13'd4294;

    // Sub-unit divisor: microseconds per millisecond, milliseconds per second
    localparam logic [SUB_W-1:0] SUB_DIV = 10'd1000;

    // Per-cycle control of one divider stage
    typedef struct packed {
        logic clr;   // clear the partial remainder
        logic en;    // take one dividend bit
    } stage_ctrl_t;

endpackage

`default_nettype wire

>>> src/cets_div_stage.sv
// ----------------------------------------------------------------------------
// cets_div_stage: one bit-serial restoring divider stage
// Takes one dividend bit per enabled cycle, MSB first, and emits one
// registered quotient bit per enabled cycle; the remainder is left after the last bit.
// ----------------------------------------------------------------------------
`default_nettype none

module cets_div_stage #(
    parameter int DW = 13
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire cets_pkg::stage_ctrl_t ctrl,
    input  wire logic                 bit_in,
    input  wire logic [DW-1:0]        divisor,
    output logic                      q,
    output logic [DW-1:0]             rem
);

    logic [DW-1:0] rem_reg;
    logic [DW-1:0] rem_next;
    logic          q_reg;
    logic          q_next;
    logic [DW:0]   partial;
    logic [DW:0]   diff;

    // Shift in the next bit and try a subtract
    always_comb
    begin
        partial = {rem_reg, bit_in};
        diff    = partial - {1'b0, divisor};
        if (partial >= {1'b0, divisor})
        begin
            q_next   = 1'b1;
            rem_next = diff[DW-1:0];
        end
        else
        begin
            q_next   = 1'b0;
            rem_next = partial[DW-1:0];
        end
    end

    // Hold remainder and quotient bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg <= '0;
            q_reg   <= 1'b0;
        end
        else if (ctrl.clr)
        begin
            rem_reg <= '0;
            q_reg   <= 1'b0;
        end
        else if (ctrl.en)
        begin
            rem_reg <= rem_next;
            q_reg   <= q_next;
        end
    end

    assign q   = q_reg;
    assign rem = rem_reg;

endmodule

`default_nettype wire

>>> src/counter_extend_time_split_unit.sv
// ----------------------------------------------------------------------------
// counter_extend_time_split_unit: counter wrap extension and timestamp split
// Extends a free-running counter by a wrap count, then divides the tick count
// by the clock in MHz and splits the microseconds into s / ms / us.
// ----------------------------------------------------------------------------
//
//  channel  | handshake              | payload
//  ---------+------------------------+----------------------------------------
//  in       | in_valid / in_stall    | counter_sample
//  out      | out_valid / out_stall  | seconds, milliseconds, microseconds,
//           |                        | total_us, wrapped
//  cfg      | cfg_we                 | cfg_wdata (clock_mhz)
//
//  An item runs through three chained bit-serial divider stages (/MHz, /1000,
//  /1000) over a TW-bit dividend (TW = 32 + COUNTER_WIDTH, 64 at default),
//  then loads the output register; no new item is taken before that load.
//  in_stall is high while an item is in flight or waiting for the output slot.
//  A stalled result holds in the output register; reset clears wrap state.
// ----------------------------------------------------------------------------
`default_nettype none

module counter_extend_time_split_unit #(
    parameter int COUNTER_WIDTH = 32
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic [cets_pkg::SAMPLE_W-1:0]     counter_sample,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic [cets_pkg::SECONDS_W-1:0]         seconds,
    output logic [cets_pkg::SUB_W-1:0]             milliseconds,
    output logic [cets_pkg::SUB_W-1:0]             microseconds,
    output logic [cets_pkg::TOTAL_W-1:0]           total_us,
    output logic                                   wrapped,
    input  wire logic                              cfg_we,
    input  wire logic [cets_pkg::MHZ_W-1:0]        cfg_wdata
);

    localparam int TW    = cets_pkg::SAMPLE_W + COUNTER_WIDTH;
    localparam int CNT_W = $clog2(TW + 3);

    localparam logic [CNT_W-1:0] A_END = CNT_W'(TW);
    localparam logic [CNT_W-1:0] B_END = CNT_W'(TW + 1);
    localparam logic [CNT_W-1:0] C_END = CNT_W'(TW + 2);
    localparam logic [CNT_W-1:0] LAST  = CNT_W'(TW + 2);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_FINISH
    } state_t;

    state_t state_reg;

    logic [cets_pkg::MHZ_W-1:0]     clock_mhz_reg;
    logic [cets_pkg::MHZ_W-1:0]     divisor_reg;
    logic [cets_pkg::MHZ_W-1:0]     mhz_clamped;
    logic [COUNTER_WIDTH-1:0]       last_reg;
    logic [cets_pkg::SAMPLE_W-1:0]  wrap_reg;
    logic [cets_pkg::SAMPLE_W-1:0]  wrap_next;
    logic [COUNTER_WIDTH-1:0]       sample;
    logic                           wrap_hit;
    logic                           wrap_flag_reg;
    logic [TW-1:0]                  ticks_reg;
    logic [TW-1:0]                  total_reg;
    logic [cets_pkg::SECONDS_W-1:0] secs_reg;
    logic [CNT_W-1:0]               cnt_reg;

    logic                           out_valid_reg;
    logic [cets_pkg::SECONDS_W-1:0] seconds_reg;
    logic [cets_pkg::SUB_W-1:0]     ms_reg;
    logic [cets_pkg::SUB_W-1:0]     us_reg;
    logic [cets_pkg::TOTAL_W-1:0]   total_us_reg;
    logic                           wrapped_reg;

    logic                  in_xfer;
    logic                  out_free;
    logic                  run;
    logic                  en_a;
    logic                  en_b;
    logic                  en_c;
    cets_pkg::stage_ctrl_t ctrl_a;
    cets_pkg::stage_ctrl_t ctrl_b;
    cets_pkg::stage_ctrl_t ctrl_c;
    logic                  q_a;
    logic                  q_b;
    logic                  q_c;
    logic [cets_pkg::MHZ_W-1:0] rem_a;
    logic [cets_pkg::SUB_W-1:0] rem_b;
    logic [cets_pkg::SUB_W-1:0] rem_c;

    // Handshake
    assign in_stall = (state_reg != S_IDLE);
    assign in_xfer  = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    // Wrap detection on the masked sample
    assign sample    = counter_sample[COUNTER_WIDTH-1:0];
    assign wrap_hit  = (sample < last_reg);
    assign wrap_next = wrap_reg + cets_pkg::SAMPLE_W'(wrap_hit);

    // Clamp clock to its legal range
    always_comb
    begin
        if (clock_mhz_reg == '0)
            mhz_clamped = cets_pkg::CLK_MHZ_MIN;
        else if (clock_mhz_reg > cets_pkg::CLK_MHZ_MAX)
            mhz_clamped = cets_pkg::CLK_MHZ_MAX;
        else
            mhz_clamped = clock_mhz_reg;
    end

    // Stage enables: each stage's enable window starts and ends in the cycle after the one before
    assign run  = (state_reg == S_RUN);
    assign en_a = run && (cnt_reg < A_END);
    assign en_b = run && (cnt_reg >= CNT_W'(1)) && (cnt_reg < B_END);
    assign en_c = run && (cnt_reg >= CNT_W'(2)) && (cnt_reg < C_END);

    assign ctrl_a = '{clr: in_xfer, en: en_a};
    assign ctrl_b = '{clr: in_xfer, en: en_b};
    assign ctrl_c = '{clr: in_xfer, en: en_c};

    // Ticks / MHz gives total microseconds
    cets_div_stage #(.DW(cets_pkg::MHZ_W)) u_div_mhz (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (ctrl_a),
        .bit_in  (ticks_reg[TW-1]),
        .divisor (divisor_reg),
        .q       (q_a),
        .rem     (rem_a)
    );

    // Total us / 1000: remainder is the microsecond part
    cets_div_stage #(.DW(cets_pkg::SUB_W)) u_div_us (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (ctrl_b),
        .bit_in  (q_a),
        .divisor (cets_pkg::SUB_DIV),
        .q       (q_b),
        .rem     (rem_b)
    );

    // Milliseconds / 1000: quotient is seconds, remainder the ms part
    cets_div_stage #(.DW(cets_pkg::SUB_W)) u_div_ms (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (ctrl_c),
        .bit_in  (q_b),
        .divisor (cets_pkg::SUB_DIV),
        .q       (q_c),
        .rem     (rem_c)
    );

    // Clock register write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clock_mhz_reg <= cets_pkg::CLK_MHZ_RESET;
        else if (cfg_we)
            clock_mhz_reg <= cfg_wdata;
    end

    // Sequencer, wrap state, shift registers and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            last_reg      <= '0;
            wrap_reg      <= '0;
            wrap_flag_reg <= 1'b0;
            divisor_reg   <= cets_pkg::CLK_MHZ_MIN;
            ticks_reg     <= '0;
            total_reg     <= '0;
            secs_reg      <= '0;
            out_valid_reg <= 1'b0;
            seconds_reg   <= '0;
            ms_reg        <= '0;
            us_reg        <= '0;
            total_us_reg  <= '0;
            wrapped_reg   <= 1'b0;
        end
        else
        begin
            // Drop the result once it is taken, unless the next one loads
            if (out_valid_reg && !out_stall && (state_reg != S_FINISH))
                out_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (in_xfer)
                    begin
                        last_reg      <= sample;
                        wrap_reg      <= wrap_next;
                        wrap_flag_reg <= wrap_hit;
                        divisor_reg   <= mhz_clamped;
                        ticks_reg     <= {wrap_next, sample};
                        total_reg     <= '0;
                        secs_reg      <= '0;
                        cnt_reg       <= '0;
                        state_reg     <= S_RUN;
                    end
                end
                S_RUN:
                begin
                    // Advance the dividend and collect quotient bits
                    if (en_a)
                        ticks_reg <= {ticks_reg[TW-2:0], 1'b0};
                    if (en_b)
                        total_reg <= {total_reg[TW-2:0], q_a};
                    if (cnt_reg >= CNT_W'(3))
                        secs_reg <= {secs_reg[cets_pkg::SECONDS_W-2:0], q_c};
                    if (cnt_reg == LAST)
                        state_reg <= S_FINISH;
                    else
                        cnt_reg <= cnt_reg + CNT_W'(1);
                end
                S_FINISH:
                begin
                    // Load the result when the output slot is free
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        seconds_reg   <= secs_reg;
                        ms_reg        <= rem_c;
                        us_reg        <= rem_b;
                        total_us_reg  <= cets_pkg::TOTAL_W'(total_reg);
                        wrapped_reg   <= wrap_flag_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid    = out_valid_reg;
    assign seconds      = seconds_reg;
    assign milliseconds = ms_reg;
    assign microseconds = us_reg;
    assign total_us     = total_us_reg;
    assign wrapped      = wrapped_reg;

endmodule

`default_nettype wire

>>> tb/counter_extend_time_split_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// counter_extend_time_split_unit_tb: self-checking bench for the timestamp unit
// Feeds counter samples (corner values, then long runs of forward steps, wraps
// and repeats) under several clock settings, predicts the wrap-extended
// s / ms / us split of every transfer and checks each result field by field,
// with random input gaps and output stalls in all but the quiet phases.
// ----------------------------------------------------------------------------

module counter_extend_time_split_unit_tb;

    localparam int CNT_W       = 32;
    localparam int ITEM_CYCLES = CNT_W + 36;
    localparam int IDLE_LIMIT  = 4000;
    localparam int MAX_REPORTS = 40;
    localparam int PHASE_ITEMS = 118;
    localparam int NUM_PHASES  = 10;

    localparam logic [63:0] US_PER_SEC  = 64'd1000000;
    localparam logic [63:0] US_PER_MSEC = 64'd1000;

    typedef struct packed {
        logic [cets_pkg::SECONDS_W-1:0] seconds;
        logic [cets_pkg::SUB_W-1:0]     milliseconds;
        logic [cets_pkg::SUB_W-1:0]     microseconds;
        logic [cets_pkg::TOTAL_W-1:0]   total_us;
        logic                           wrapped;
    } stamp_t;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           in_valid = 1'b0;
    logic                           in_stall;
    logic [cets_pkg::SAMPLE_W-1:0]  counter_sample = '0;
    logic                           out_valid;
    logic                           out_stall = 1'b0;
    logic [cets_pkg::SECONDS_W-1:0] seconds;
    logic [cets_pkg::SUB_W-1:0]     milliseconds;
    logic [cets_pkg::SUB_W-1:0]     microseconds;
    logic [cets_pkg::TOTAL_W-1:0]   total_us;
    logic                           wrapped;
    logic                           cfg_we = 1'b0;
    logic [cets_pkg::MHZ_W-1:0]     cfg_wdata = cets_pkg::CLK_MHZ_RESET;

    // Predictor state: clock register copy and wrap extension
    logic [cets_pkg::MHZ_W-1:0]     clock_setting = cets_pkg::CLK_MHZ_RESET;
    logic [cets_pkg::SAMPLE_W-1:0]  prev_sample = '0;
    logic [31:0]                    wrap_total = '0;

    // Stimulus and expectation stores
    logic [cets_pkg::SAMPLE_W-1:0]  sample_q [$];
    stamp_t                         pending_stamps [$];
    stamp_t                         expected_stamp;
    logic [cets_pkg::SAMPLE_W-1:0]  gen_prev = '0;
    int                             items_pending = 0;
    int                             error_count = 0;
    int                             idle_cycles = 0;
    int unsigned                    send_gap = 0;
    int unsigned                    stall_left = 0;
    bit                             quiet_phase = 1'b0;
    bit                             drain_hold = 1'b0;
    bit                             sent_now;

    counter_extend_time_split_unit #(
        .COUNTER_WIDTH (CNT_W)
    ) DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .counter_sample (counter_sample),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .seconds        (seconds),
        .milliseconds   (milliseconds),
        .microseconds   (microseconds),
        .total_us       (total_us),
        .wrapped        (wrapped),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata)
    );

    // Clock: 2 ns period
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Extend one sample by the wrap count and split the ticks into s / ms / us
    function automatic stamp_t split_timestamp(input logic [cets_pkg::SAMPLE_W-1:0] raw);
        logic [63:0] mask;
        logic [63:0] sample;
        logic [63:0] mhz;
        logic [63:0] per_s;
        logic [63:0] per_ms;
        logic [63:0] ticks;
        logic [63:0] secs;
        logic [63:0] rest;
        logic [63:0] ms;
        logic [63:0] us;
        stamp_t      r;
        mask = (64'd1 << CNT_W) - 64'd1;
        sample = {32'd0, raw} & mask;
        r.wrapped = 1'b0;
        if (sample[cets_pkg::SAMPLE_W-1:0] < prev_sample)
        begin
            wrap_total = wrap_total + 32'd1;
            r.wrapped = 1'b1;
        end
        prev_sample = sample[cets_pkg::SAMPLE_W-1:0];
        // clamp the clock into its legal range
        if (clock_setting < cets_pkg::CLK_MHZ_MIN)
            mhz = 64'(cets_pkg::CLK_MHZ_MIN);
        else if (clock_setting > cets_pkg::CLK_MHZ_MAX)
            mhz = 64'(cets_pkg::CLK_MHZ_MAX);
        else
            mhz = 64'(clock_setting);
        per_s = mhz * US_PER_SEC;
        per_ms = mhz * US_PER_MSEC;
        ticks = ({32'd0, wrap_total} << CNT_W) + sample;
        secs = ticks / per_s;
        rest = ticks - secs * per_s;
        ms = rest / per_ms;
        rest = rest - ms * per_ms;
        us = rest / mhz;
        r.seconds = secs[cets_pkg::SECONDS_W-1:0];
        r.milliseconds = ms[cets_pkg::SUB_W-1:0];
        r.microseconds = us[cets_pkg::SUB_W-1:0];
        r.total_us = secs * US_PER_SEC + ms * US_PER_MSEC + us;
        return r;
    endfunction

    // Gap or stall length: mostly short, a few long
    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(99, 0);
        if (roll < 45)
            return 0;
        if (roll < 80)
            return $urandom_range(4, 1);
        if (roll < 95)
            return $urandom_range(40, 5);
        return $urandom_range(250, 60);
    endfunction

    // Next counter sample: forward steps, repeats, wraps, values near the top, random values
    function automatic logic [cets_pkg::SAMPLE_W-1:0] next_sample();
        logic [cets_pkg::SAMPLE_W-1:0] s;
        logic [cets_pkg::SAMPLE_W-1:0] step_mask;
        int unsigned                   roll;
        roll = $urandom_range(99, 0);
        step_mask = (32'd1 << $urandom_range(31, 1)) - 32'd1;
        if (roll < 55)
            s = gen_prev + 32'd1 + ($urandom & step_mask);
        else if (roll < 65)
            s = gen_prev;
        else if (roll < 85)
            s = (gen_prev == '0) ? $urandom : $urandom_range(gen_prev - 32'd1, 0);
        else if (roll < 92)
            s = 32'hFFFF_FFFF - $urandom_range(15, 0);
        else
            s = $urandom;
        gen_prev = s;
        return s;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (error_count < MAX_REPORTS)
            $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        error_count++;
    endtask

    task automatic queue_sample(input logic [cets_pkg::SAMPLE_W-1:0] s);
        sample_q.push_back(s);
        items_pending++;
    endtask

    // Hold until every queued sample is taken and every result has arrived
    task automatic wait_idle();
        while (items_pending != 0 || pending_stamps.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_clock(input logic [cets_pkg::MHZ_W-1:0] value);
        wait_idle();
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        clock_setting = value;
    endtask

    // Input driver: predict on each transfer, then present the next sample
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            counter_sample <= '0;
            send_gap = 0;
        end
        else
        begin
            sent_now = in_valid && !in_stall;
            if (sent_now)
            begin
                pending_stamps.push_back(split_timestamp(counter_sample));
                items_pending--;
            end
            if (!in_valid || sent_now)
            begin
                if (drain_hold)
                begin
                    if (pending_stamps.size() == 0)
                        drain_hold = 1'b0;
                    in_valid <= 1'b0;
                end
                else if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (sample_q.size() != 0)
                begin
                    counter_sample <= sample_q.pop_front();
                    in_valid <= 1'b1;
                    send_gap = quiet_phase ? 0 : pick_gap();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Output monitor: check each transfer against the oldest expectation
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (pending_stamps.size() == 0)
                    report_mismatch("result with none expected", total_us, 64'd0);
                else
                begin
                    expected_stamp = pending_stamps.pop_front();
                    if (seconds !== expected_stamp.seconds)
                        report_mismatch("seconds", seconds, expected_stamp.seconds);
                    if (milliseconds !== expected_stamp.milliseconds)
                        report_mismatch("milliseconds", milliseconds,
                                        expected_stamp.milliseconds);
                    if (microseconds !== expected_stamp.microseconds)
                        report_mismatch("microseconds", microseconds,
                                        expected_stamp.microseconds);
                    if (total_us !== expected_stamp.total_us)
                        report_mismatch("total_us", total_us, expected_stamp.total_us);
                    if (wrapped !== expected_stamp.wrapped)
                        report_mismatch("wrapped", wrapped, expected_stamp.wrapped);
                end
            end
            // advance or start a stall
            if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else if (!quiet_phase && $urandom_range(5, 0) == 0)
            begin
                stall_left = pick_gap();
                out_stall <= (stall_left != 0);
                if (stall_left != 0)
                    stall_left--;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // Watchdog: end the run when nothing transfers for too long
    always @(posedge clk)
    begin
        if (rst_n && !((in_valid && !in_stall) || (out_valid && !out_stall)))
            idle_cycles++;
        else
            idle_cycles = 0;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Stimulus sequence
    initial
    begin
        logic [cets_pkg::SAMPLE_W-1:0] corner [18];
        logic [cets_pkg::MHZ_W-1:0]    phase_clock [NUM_PHASES];
        corner = '{32'd0, 32'd1, 32'd79, 32'd80, 32'd79999, 32'd80000,
                   32'd79999999, 32'd80000000, 32'h7FFF_FFFF, 32'h8000_0000,
                   32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 32'hAAAA_AAAA,
                   32'h5555_5555, 32'h5555_5555, 32'hFFFF_FFFE, 32'd1};
        phase_clock = '{13'd1, 13'd4294, 13'd0, 13'd8191, 13'd4295, 13'd1000,
                        13'd2, 13'd3, 13'd2, 13'd80};
        phase_clock[6] = $urandom_range(4293, 2);
        phase_clock[8] = $urandom_range(8191, 1);

        repeat (2) @(posedge clk);
        @(negedge clk) rst_n = 1'b1;

        // corner samples under the reset clock
        for (int i = 0; i < 18; i++)
            queue_sample(corner[i]);
        gen_prev = corner[17];

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            write_clock(phase_clock[ph]);
            quiet_phase = (ph % 4 == 2);
            for (int n = 0; n < PHASE_ITEMS; n++)
                queue_sample(next_sample());
            // hold the sender once midway until every result is out
            if (ph % 4 == 1)
            begin
                while (sample_q.size() > PHASE_ITEMS / 2)
                    @(posedge clk);
                drain_hold = 1'b1;
            end
        end

        wait_idle();
        repeat (2 * ITEM_CYCLES) @(posedge clk);
        if (error_count == 0 && pending_stamps.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
